// ===== src/rebd_pkg.sv =====
// Shared types, codes and the quadrature decode table for the rotary
// encoder event block. No dependencies.
package rebd_pkg;

   localparam int ACTION_W = 2;
   localparam int EVENT_W  = 3;
   localparam int TIME_W   = 32;
   localparam int HOLD_W   = 16;

   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [EVENT_W-1:0]  event_type;
   typedef logic [TIME_W-1:0]   time_type;
   typedef logic [HOLD_W-1:0]   hold_type;

   localparam action_type ACT_TICK = 2'd0;
   localparam action_type ACT_POP  = 2'd1;
   localparam action_type ACT_LOAD = 2'd2;
   localparam action_type ACT_NOP  = 2'd3;

   localparam event_type EV_NONE  = 3'd0;
   localparam event_type EV_CW    = 3'd1;
   localparam event_type EV_CCW   = 3'd2;
   localparam event_type EV_CLICK = 3'd3;
   localparam event_type EV_HOLD  = 3'd4;

   localparam hold_type HOLD_RESET = 16'd1000;

   // Index is {old position, new A, new B}; a jump of both channels or
   // no change decodes to no event.
   function automatic event_type quad_event(input logic [3:0] idx);
      event_type ev;
      unique case (idx)
         4'd2, 4'd4, 4'd11, 4'd13: ev = EV_CW;
         4'd1, 4'd7, 4'd8, 4'd14:  ev = EV_CCW;
         default:                  ev = EV_NONE;
      endcase
      return ev;
   endfunction

endpackage

// ===== src/rebd_req_if.sv =====
// Request channel interface: valid/ready handshake with action, raw pins
// and time stamp. Depends on rebd_pkg.
interface rebd_req_if;
   logic                 valid;
   logic                 ready;
   rebd_pkg::action_type action;
   logic                 pin_a;
   logic                 pin_b;
   logic                 pin_button;
   rebd_pkg::time_type   now_ms;

   modport source (output valid, action, pin_a, pin_b, pin_button, now_ms, input ready);
   modport sink   (input valid, action, pin_a, pin_b, pin_button, now_ms, output ready);
endinterface

// ===== src/rebd_rsp_if.sv =====
// Response channel interface: valid/ready handshake with popped event and
// queue-pending flag. Depends on rebd_pkg.
interface rebd_rsp_if;
   logic                valid;
   logic                ready;
   rebd_pkg::event_type event_res;
   logic                pending;

   modport source (output valid, event_res, pending, input ready);
   modport sink   (input valid, event_res, pending, output ready);
endinterface

// ===== src/rotary_encoder_button_events_top.sv =====
// Rotary encoder with push button: debounce, quadrature decode, event queue.
// Depends on rebd_pkg, rebd_req_if and rebd_rsp_if.
//
// Usage:
//   req_ch carries one request per handshake: a sample tick (raw A, B and
//   active-low button pins plus a millisecond time stamp), a pop of the
//   oldest queued event, or a load of the encoder position from the pins.
//   rsp_ch returns exactly one response per request: the popped event
//   (none for anything but a pop) and whether the queue still holds events.
//   csr_we/csr_wdata write the hold threshold in ms (1000 after reset).
// Timing:
//   A request is decoded and all state is updated at the edge that accepts
//   it; the response sits in the output register from the next cycle. One
//   request per cycle is sustained while rsp_ch.ready is high, limited only
//   by the single response register.
// Reset:
//   Synchronous reset clears debounce histories, stable levels, position,
//   button state and the queue pointers; hold threshold returns to 1000.
// Stall:
//   While rsp_ch.ready is low and a response is held, req_ch.ready drops
//   and no request is taken; the held response stays unchanged.
module rotary_encoder_button_events_top #(
   parameter int QUEUE_DEPTH  = 8,
   parameter int DEBOUNCE_LEN = 3
) (
   input  logic              clock,
   input  logic              reset,
   rebd_req_if.sink          req_ch,
   rebd_rsp_if.source        rsp_ch,
   input  logic              csr_we,
   input  rebd_pkg::hold_type csr_wdata
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef logic [PTR_W-1:0]        ptr_type;
   typedef logic [DEBOUNCE_LEN-1:0] hist_type;

   // Advance a ring pointer with wrap at the queue depth.
   function automatic ptr_type ptr_inc(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

   // Stable level follows only a window of all ones or all zeros.
   function automatic logic deb_level(input hist_type h, input logic stable);
      logic r;
      if (h == '1) begin
         r = 1'b1;
      end else if (h == '0) begin
         r = 1'b0;
      end else begin
         r = stable;
      end
      return r;
   endfunction

   // State registers
   hist_type            hist_a_ff, hist_a_in;
   hist_type            hist_b_ff, hist_b_in;
   hist_type            hist_btn_ff, hist_btn_in;
   logic                stable_a_ff, stable_a_in;
   logic                stable_b_ff, stable_b_in;
   logic                stable_btn_ff, stable_btn_in;
   logic [1:0]          position_ff, position_in;
   logic                pressed_ff, pressed_in;
   logic                hold_done_ff, hold_done_in;
   rebd_pkg::time_type  press_start_ff, press_start_in;
   ptr_type             head_ff, head_in;
   ptr_type             tail_ff, tail_in;
   rebd_pkg::hold_type  hold_ff, hold_in;
   rebd_pkg::event_type ring_ff [QUEUE_DEPTH];

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   rebd_pkg::event_type rsp_event_ff, rsp_event_in;
   logic                rsp_pending_ff, rsp_pending_in;

   // Tick decode
   logic                accept;
   logic                pop_take;
   hist_type            tick_hist_a, tick_hist_b, tick_hist_btn;
   logic                a_now, b_now, btn_now;
   rebd_pkg::event_type dir_ev;
   logic                dir_push;
   logic                click_push, hold_push;
   logic                tk_pressed, tk_hold_done;
   rebd_pkg::time_type  tk_press_start;
   rebd_pkg::time_type  elapsed;
   rebd_pkg::event_type btn_ev;
   logic                wr_a, wr_b;
   ptr_type             mid_ptr;

   assign req_ch.ready     = !rsp_valid_ff || rsp_ch.ready;
   assign accept           = req_ch.valid && req_ch.ready;
   assign pop_take         = accept && (req_ch.action == rebd_pkg::ACT_POP) &&
                             (head_ff != tail_ff);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.event_res = rsp_event_ff;
   assign rsp_ch.pending   = rsp_pending_ff;

   // Tick datapath: computed every cycle, used only when a tick is accepted.
   always_comb begin
      tick_hist_a   = {hist_a_ff[DEBOUNCE_LEN-2:0], req_ch.pin_a};
      tick_hist_b   = {hist_b_ff[DEBOUNCE_LEN-2:0], req_ch.pin_b};
      tick_hist_btn = {hist_btn_ff[DEBOUNCE_LEN-2:0], ~req_ch.pin_button};
      a_now         = deb_level(tick_hist_a, stable_a_ff);
      b_now         = deb_level(tick_hist_b, stable_b_ff);
      btn_now       = deb_level(tick_hist_btn, stable_btn_ff);

      dir_ev   = rebd_pkg::quad_event({position_ff, a_now, b_now});
      dir_push = ((a_now != stable_a_ff) || (b_now != stable_b_ff)) &&
                 (dir_ev != rebd_pkg::EV_NONE);

      tk_pressed     = pressed_ff;
      tk_hold_done   = hold_done_ff;
      tk_press_start = press_start_ff;
      click_push     = 1'b0;
      if (btn_now != stable_btn_ff) begin
         if (btn_now) begin
            tk_pressed     = 1'b1;
            tk_press_start = req_ch.now_ms;
            tk_hold_done   = 1'b0;
         end else begin
            click_push = pressed_ff && !hold_done_ff;
            tk_pressed = 1'b0;
         end
      end

      // Wrapping press time against the threshold
      elapsed   = req_ch.now_ms - tk_press_start;
      hold_push = tk_pressed && !tk_hold_done &&
                  (elapsed >= rebd_pkg::time_type'(hold_ff));
      if (hold_push) begin
         tk_hold_done = 1'b1;
      end
      btn_ev = click_push ? rebd_pkg::EV_CLICK : rebd_pkg::EV_HOLD;

      // Direction event first, then click or hold; drop each when full.
      wr_a    = dir_push && (ptr_inc(tail_ff) != head_ff);
      mid_ptr = wr_a ? ptr_inc(tail_ff) : tail_ff;
      wr_b    = (click_push || hold_push) && (ptr_inc(mid_ptr) != head_ff);
   end

   // Next-state selection per accepted request
   always_comb begin
      hist_a_in      = hist_a_ff;
      hist_b_in      = hist_b_ff;
      hist_btn_in    = hist_btn_ff;
      stable_a_in    = stable_a_ff;
      stable_b_in    = stable_b_ff;
      stable_btn_in  = stable_btn_ff;
      position_in    = position_ff;
      pressed_in     = pressed_ff;
      hold_done_in   = hold_done_ff;
      press_start_in = press_start_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      hold_in        = csr_we ? csr_wdata : hold_ff;
      rsp_event_in   = rsp_event_ff;
      rsp_pending_in = rsp_pending_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;

      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_event_in = rebd_pkg::EV_NONE;
         unique case (req_ch.action)
            rebd_pkg::ACT_TICK: begin
               hist_a_in      = tick_hist_a;
               hist_b_in      = tick_hist_b;
               hist_btn_in    = tick_hist_btn;
               stable_a_in    = a_now;
               stable_b_in    = b_now;
               stable_btn_in  = btn_now;
               if ((a_now != stable_a_ff) || (b_now != stable_b_ff)) begin
                  position_in = {a_now, b_now};
               end
               pressed_in     = tk_pressed;
               hold_done_in   = tk_hold_done;
               press_start_in = tk_press_start;
               tail_in        = wr_b ? ptr_inc(mid_ptr) : mid_ptr;
            end
            rebd_pkg::ACT_POP: begin
               if (pop_take) begin
                  head_in = ptr_inc(head_ff);
               end
            end
            rebd_pkg::ACT_LOAD: begin
               position_in = {req_ch.pin_a, req_ch.pin_b};
            end
            default: begin
            end
         endcase
         rsp_pending_in = (head_in != tail_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_a_ff     <= '0;
         hist_b_ff     <= '0;
         hist_btn_ff   <= '0;
         stable_a_ff   <= 1'b0;
         stable_b_ff   <= 1'b0;
         stable_btn_ff <= 1'b0;
         position_ff   <= '0;
         pressed_ff    <= 1'b0;
         hold_done_ff  <= 1'b0;
         press_start_ff <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         hold_ff       <= rebd_pkg::HOLD_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hist_a_ff     <= hist_a_in;
         hist_b_ff     <= hist_b_in;
         hist_btn_ff   <= hist_btn_in;
         stable_a_ff   <= stable_a_in;
         stable_b_ff   <= stable_b_in;
         stable_btn_ff <= stable_btn_in;
         position_ff   <= position_in;
         pressed_ff    <= pressed_in;
         hold_done_ff  <= hold_done_in;
         press_start_ff <= press_start_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         hold_ff       <= hold_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Response payload: no reset needed; a pop reads the ring slot at the head.
   always_ff @(posedge clock) begin
      if (pop_take) begin
         rsp_event_ff <= ring_ff[head_ff];
      end else begin
         rsp_event_ff <= rsp_event_in;
      end
      rsp_pending_ff <= rsp_pending_in;
   end

   // Event ring: up to two writes per tick, at the tail and, if the tail was taken, the slot after.
   always_ff @(posedge clock) begin
      if (accept && (req_ch.action == rebd_pkg::ACT_TICK)) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (wr_a && (tail_ff == ptr_type'(i))) begin
               ring_ff[i] <= dir_ev;
            end
            if (wr_b && (mid_ptr == ptr_type'(i))) begin
               ring_ff[i] <= btn_ev;
            end
         end
      end
   end

   // Held response always reports the live queue occupancy.
   a_pending_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pending_ff == (head_ff != tail_ff)))
      else $error("pending flag disagrees with queue pointers");

   // Only a pop can return an event.
   a_non_pop_none: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_ch.action != rebd_pkg::ACT_POP))
      |=> (rsp_event_ff == rebd_pkg::EV_NONE))
      else $error("event returned for a non-pop request");

   // Pop of an empty queue returns nothing and leaves the head alone.
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_ch.action == rebd_pkg::ACT_POP) && (head_ff == tail_ff))
      |=> ((rsp_event_ff == rebd_pkg::EV_NONE) && $stable(head_ff)))
      else $error("empty pop changed the queue or returned an event");

endmodule
